@@ src/aesk_pkg.sv @@
// Package for the AES-128 counter-mode key stream block.
// Holds widths, register indexes, the S-box and round helper functions.
`timescale 1ns / 1ps
`default_nettype none
package aesk_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int CNT_W      = 7;
    localparam int BIDX_W     = $clog2(MAX_BLOCKS + 1);
    localparam int ROUNDS     = 10;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_IV_LOW   = 2'd2;
    localparam logic [1:0] REG_IV_HIGH  = 2'd3;

    typedef logic [127:0] t_block;

    // one pipeline slot: state, round key and the valid and last tags that travel with it
    typedef struct packed {
        logic   valid;
        logic   last;
        t_block state;
        t_block rkey;
    } t_slot;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of a block sits in bits 8n+7:8n
    function automatic logic [7:0] byte_of(input t_block b, input int n);
        return b[8*n +: 8];
    endfunction

    // next round key from the previous one
    function automatic t_block next_key(input t_block k, input logic [3:0] r);
        t_block     o;
        logic [7:0] t0, t1, t2, t3;
        t0 = sbox(byte_of(k, 13)) ^ rcon(r);
        t1 = sbox(byte_of(k, 14));
        t2 = sbox(byte_of(k, 15));
        t3 = sbox(byte_of(k, 12));
        o[31:0]   = k[31:0]   ^ {t3, t2, t1, t0};
        o[63:32]  = k[63:32]  ^ o[31:0];
        o[95:64]  = k[95:64]  ^ o[63:32];
        o[127:96] = k[127:96] ^ o[95:64];
        return o;
    endfunction

    // one AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
    function automatic t_block aes_round(input t_block s, input t_block k,
                                         input logic mix);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[8*(c*4+i) +: 8] = sbox(s[8*(((c + i) % 4)*4 + i) +: 8]);
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[8*(c*4)   +: 8];
                a1 = t[8*(c*4+1) +: 8];
                a2 = t[8*(c*4+2) +: 8];
                a3 = t[8*(c*4+3) +: 8];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[8*(c*4)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                t[8*(c*4+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                t[8*(c*4+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                t[8*(c*4+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        return t ^ k;
    endfunction

endpackage
`default_nettype wire

@@ src/aesk_counter.sv @@
// Counter block sequencer: walks the requested block range and forms IV + index.
// Depends on aesk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aesk_counter import aesk_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire logic [63:0]       i_start_block,
    input  wire logic [CNT_W-1:0]  i_block_count,
    input  wire logic [127:0]      i_iv,
    input  wire logic              i_adv,
    output logic                   o_valid,
    output logic                   o_last,
    output t_block                 o_ctr
);
    logic [63:0]       r_off;
    logic [BIDX_W-1:0] r_left;
    logic              r_busy;
    logic [CNT_W-1:0]  w_cnt;
    logic [63:0]       w_lo;
    logic              w_cy;

    // saturate the count
    assign w_cnt = (i_block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : i_block_count;

    assign o_req_ready = !r_busy;
    assign o_valid     = r_busy;
    assign o_last      = (r_left == BIDX_W'(1));
    assign {w_cy, w_lo} = {1'b0, i_iv[63:0]} + {1'b0, r_off};
    assign o_ctr        = {i_iv[127:64] + {63'd0, w_cy}, w_lo};

    // take a request, then step one block per issued slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (!r_busy) begin
            if (i_req_valid && w_cnt != '0) begin
                r_busy <= 1'b1;
                r_left <= BIDX_W'(w_cnt);
            end
        end else if (i_adv) begin
            r_left <= r_left - BIDX_W'(1);
            if (r_left == BIDX_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) r_off <= i_start_block;
        else if (i_adv) r_off <= r_off + 64'd1;
    end
endmodule
`default_nettype wire

@@ src/aesk_round.sv @@
// One registered AES round stage with its own on-the-fly key step.
// Depends on aesk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aesk_round import aesk_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [3:0] i_rnd,
    input  wire t_slot      i_slot,
    output t_slot           o_slot
);
    t_slot  r_slot;
    t_block w_key;

    assign w_key  = next_key(i_slot.rkey, i_rnd);
    assign o_slot = r_slot;

    // advance on enable, hold otherwise; only the valid bit is cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_en) begin
            r_slot.valid <= i_slot.valid;
            r_slot.last  <= i_slot.last;
            r_slot.rkey  <= w_key;
            r_slot.state <= aes_round(i_slot.state, w_key, i_rnd != 4'(ROUNDS));
        end
    end
endmodule
`default_nettype wire

@@ src/aes128_ctr_keystream.sv @@
// Top level of the AES-128 counter-mode key stream generator.
// Depends on aesk_pkg, aesk_counter and aesk_round.
//
// Usage:
//  - Write key_low, key_high, iv_low, iv_high (index 0..3) on the config
//    channel while idle; other indexes are ignored.
//  - Each s_axis transfer is a request: tdata = {block_count, start_block}.
//    Counts above 64 saturate to 64, a count of zero yields nothing.
//  - m_axis carries one transfer per block, tdata = {stream_high,
//    stream_low}, tlast on the final block of the request.
//  - Requests are taken one at a time: the N blocks of an accepted request are
//    issued one block per cycle while the pipeline does not stall, into a
//    ten-stage round pipeline (one register per AES round, key schedule
//    computed along it); s_axis_tready returns after the last issue.
//  - Each block goes from issue through the whitening register and the ten
//    round registers to the output; within a request one block per cycle
//    unless the output stalls.
//  - Reset clears every valid bit and the config registers to zero.
//  - When m_axis_tready is low the output stage holds; earlier stages keep
//    moving into empty slots, so bubbles close up and no block is lost or
//    repeated. A full pipeline stops issue until the receiver takes data.
`timescale 1ns / 1ps
`default_nettype none
module aes128_ctr_keystream import aesk_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: start_block[63:0], block_count[70:64], zero fill to 72 bits
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: stream_low[63:0], stream_high[127:64]
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    localparam int NST = ROUNDS + 1;

    logic [63:0] r_key_lo, r_key_hi, r_iv_lo, r_iv_hi;
    t_slot       w_slot [NST+1];
    logic        w_en   [NST+1];
    logic        w_cvalid, w_clast;
    t_block      w_ctr;
    t_block      w_key;
    t_slot       r_wht;

    assign o_cfg_ready = 1'b1;
    assign w_key       = {r_key_hi, r_key_lo};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0; r_key_hi <= '0; r_iv_lo <= '0; r_iv_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                REG_IV_LOW:   r_iv_lo  <= i_cfg_data;
                REG_IV_HIGH:  r_iv_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aesk_counter u_ctr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_start_block (s_axis_tdata[63:0]),
        .i_block_count (s_axis_tdata[70:64]),
        .i_iv          ({r_iv_hi, r_iv_lo}),
        .i_adv         (w_en[0]),
        .o_valid       (w_cvalid),
        .o_last        (w_clast),
        .o_ctr         (w_ctr)
    );

    // stage enables: a stage moves when it or anything downstream is empty, or the receiver is ready
    assign w_en[NST] = m_axis_tready || !w_slot[NST].valid;
    for (genvar g = NST - 1; g >= 0; g--) begin : g_en
        assign w_en[g] = w_en[g+1] || !w_slot[g+1].valid;
    end

    assign w_slot[0] = '{valid: w_cvalid, last: w_clast, state: w_ctr, rkey: w_key};

    // whitening stage; only the valid bit is cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wht.valid <= 1'b0;
        end else if (w_en[0]) begin
            r_wht.valid <= w_slot[0].valid;
            r_wht.last  <= w_slot[0].last;
            r_wht.state <= w_ctr ^ w_key;
            r_wht.rkey  <= w_key;
        end
    end
    assign w_slot[1] = r_wht;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_rnd
        aesk_round u_rnd (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en[g]),
            .i_rnd  (4'(g)),
            .i_slot (w_slot[g]),
            .o_slot (w_slot[g+1])
        );
    end

    assign m_axis_tvalid = w_slot[NST].valid;
    assign m_axis_tdata  = w_slot[NST].state;
    assign m_axis_tlast  = w_slot[NST].last;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_busy_noreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cvalid |-> !s_axis_tready)
        else $error("request taken while issuing");
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en[0] |-> w_slot[1].valid)
        else $error("issue stalled with empty first stage");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_aes128_ctr_keystream.sv @@
// Self-checking bench for aes128_ctr_keystream: directed vectors, then random requests.
// Predicts each key stream block with its own AES-128 or a known vector and checks each m_axis transfer.
// Depends on aesk_pkg and the DUT sources.
`timescale 1ns / 1ps
module tb_aes128_ctr_keystream;
    import aesk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;

    // S-box, entry 0 in the top byte
    localparam logic [2047:0] SUB_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
        logic        last;
    } ks_block_t;

    typedef struct {
        int          cfg_set;
        logic [63:0] start;
        logic [6:0]  count;
        logic        known;
        logic [63:0] low;
        logic [63:0] high;
    } req_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    // bench copy of the configuration
    logic [63:0]  key_lo = '0, key_hi = '0, ctr_lo = '0, ctr_hi = '0;

    ks_block_t    ks_due[$];
    int           err_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    logic         hold_rx = 1'b0;
    int           quiet_cycles = 0;

    aes128_ctr_keystream DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        return SUB_TAB[2047 - 8 * int'(a) -: 8];
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption, byte n of each 128-bit value in bits 8n+7:8n
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [7:0]   rk [176];
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   w [4];
        logic [7:0]   x, a0, a1, a2, a3, al, rc;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[8*i +: 8];
        end
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
            if (i % 16 == 0) begin
                x    = w[0];
                w[0] = sub_byte(w[1]) ^ rc;
                w[1] = sub_byte(w[2]);
                w[2] = sub_byte(w[3]);
                w[3] = sub_byte(x);
                rc   = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ rk[i];
        for (int rd = 1; rd <= 10; rd++) begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) t[c*4 + i] = sub_byte(s[((c + i) % 4)*4 + i]);
            end
            if (rd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c*4]; a1 = t[c*4 + 1]; a2 = t[c*4 + 2]; a3 = t[c*4 + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[c*4]     = a0 ^ al ^ gf_dbl(a0 ^ a1);
                    t[c*4 + 1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                    t[c*4 + 2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                    t[c*4 + 3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[rd*16 + i];
        end
        for (int i = 0; i < 16; i++) r[8*i +: 8] = s[i];
        return r;
    endfunction

    // queue the key stream blocks one request yields
    task automatic queue_keystream(input logic [63:0] start, input logic [6:0] count);
        int           n;
        logic [63:0]  off;
        logic [127:0] ctr, ks;
        ks_block_t    b;
        n = (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
        for (int k = 0; k < n; k++) begin
            off    = start + 64'(k);
            ctr    = {ctr_hi, ctr_lo} + {64'd0, off};
            ks     = aes_encrypt({key_hi, key_lo}, ctr);
            b.low  = ks[63:0];
            b.high = ks[127:64];
            b.last = (k == n - 1);
            ks_due.push_back(b);
        end
    endtask

    // offer one request, idling first at the current rate
    task automatic send_request(input logic [63:0] start, input logic [6:0] count,
                                input logic known, input logic [63:0] lo,
                                input logic [63:0] hi);
        ks_block_t b;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, count, start};
        do @(posedge i_clk); while (!s_axis_tready);
        if (known) begin
            b.low = lo; b.high = hi; b.last = 1'b1;
            ks_due.push_back(b);
        end else begin
            queue_keystream(start, count);
        end
    endtask

    // hold until every block has come out, then let the pipeline settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (ks_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers back to back
    task automatic write_regs(input logic [63:0] klo, input logic [63:0] khi,
                              input logic [63:0] vlo, input logic [63:0] vhi);
        logic [63:0] v [4];
        logic [1:0]  idx [4];
        v   = '{klo, khi, vlo, vhi};
        idx = '{REG_KEY_LOW, REG_KEY_HIGH, REG_IV_LOW, REG_IV_HIGH};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= v[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                REG_KEY_LOW:  key_lo = v[i];
                REG_KEY_HIGH: key_hi = v[i];
                REG_IV_LOW:   ctr_lo = v[i];
                default:      ctr_hi = v[i];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64;
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] rand_count;
        int p;
        p = $urandom_range(99);
        if (p < 3) return 7'd0;
        if (p < 6) return 7'($urandom_range(127, 65));
        if (p < 12) return 7'd64;
        return 7'($urandom_range(8, 1));
    endfunction

    function automatic logic [63:0] rand_start;
        if ($urandom_range(9) == 0) return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(40));
        return {$urandom, $urandom};
    endfunction

    // receiver readiness
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
    end

    // compare each output transfer with the oldest expected block
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ks_due.size() == 0) begin
                $display("%0t: unexpected block low %h high %h last %b", $realtime,
                         m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tlast);
                err_cnt++;
            end else begin
                if (m_axis_tdata[63:0] !== ks_due[0].low ||
                    m_axis_tdata[127:64] !== ks_due[0].high ||
                    m_axis_tlast !== ks_due[0].last) begin
                    $display("%0t: mismatch expected low %h high %h last %b, %s",
                             $realtime, ks_due[0].low, ks_due[0].high, ks_due[0].last,
                             $sformatf("got low %h high %h last %b",
                                       m_axis_tdata[63:0], m_axis_tdata[127:64],
                                       m_axis_tlast));
                    err_cnt++;
                end
                void'(ks_due.pop_front());
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] cfg_sets [3][4];
        req_row_t    rows [$];
        int          cur_set;
        int          tx_modes [4];
        int          rx_modes [4];
        cfg_sets[0] = '{64'd0, 64'd0, 64'd0, 64'd0};
        cfg_sets[1] = '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                        64'h7766554433221100, 64'hffeeddccbbaa9988};
        cfg_sets[2] = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                        64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
        // all-zero key and counter: known cipher of the zero block
        rows.push_back('{0, 64'd0, 7'd1, 1'b1, 64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88});
        rows.push_back('{0, 64'd5, 7'd0, 1'b0, 64'd0, 64'd0});
        rows.push_back('{0, 64'd0, 7'd64, 1'b0, 64'd0, 64'd0});
        rows.push_back('{0, 64'd100, 7'd65, 1'b0, 64'd0, 64'd0});
        rows.push_back('{0, 64'h8000_0000_0000_0000, 7'd127, 1'b0, 64'd0, 64'd0});
        rows.push_back('{0, 64'hffff_ffff_ffff_ffff, 7'd3, 1'b0, 64'd0, 64'd0});
        rows.push_back('{0, 64'hffff_ffff_ffff_fffc, 7'd8, 1'b0, 64'd0, 64'd0});
        // standard test vector key and plaintext
        rows.push_back('{1, 64'd0, 7'd1, 1'b1, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8});
        rows.push_back('{1, 64'd1, 7'd2, 1'b0, 64'd0, 64'd0});
        rows.push_back('{1, 64'hffff_ffff_ffff_ffff, 7'd0, 1'b0, 64'd0, 64'd0});
        // all-ones counter: carry out of the top dropped
        rows.push_back('{2, 64'd0, 7'd1, 1'b0, 64'd0, 64'd0});
        rows.push_back('{2, 64'd1, 7'd4, 1'b0, 64'd0, 64'd0});
        rows.push_back('{2, 64'hffff_ffff_ffff_ffff, 7'd5, 1'b0, 64'd0, 64'd0});
        rows.push_back('{2, 64'h5555_aaaa_5555_aaaa, 7'd42, 1'b0, 64'd0, 64'd0});
        tx_modes = '{0, 85, 0, 8};
        rx_modes = '{0, 0, 85, 8};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cur_set = 0;
        foreach (rows[i]) begin
            if (rows[i].cfg_set != cur_set) begin
                drain();
                cur_set = rows[i].cfg_set;
                write_regs(cfg_sets[cur_set][0], cfg_sets[cur_set][1],
                           cfg_sets[cur_set][2], cfg_sets[cur_set][3]);
            end
            send_request(rows[i].start, rows[i].count, rows[i].known,
                         rows[i].low, rows[i].high);
        end
        drain();

        // random phases across the idling modes
        for (int ph = 0; ph < 8; ph++) begin
            tx_idle_pct  = tx_modes[ph % 4];
            rx_stall_pct = rx_modes[ph % 4];
            write_regs(rand64(), rand64(), rand64(), rand64());
            for (int n = 0; n < 40; n++) begin
                send_request(rand_start(), rand_count(), 1'b0, 64'd0, 64'd0);
            end
            drain();
        end

        // long receiver hold-off while requests keep coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_regs(rand64(), rand64(), rand64(), rand64());
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        for (int n = 0; n < 20; n++) begin
            send_request({$urandom, $urandom}, 7'd8, 1'b0, 64'd0, 64'd0);
        end
        drain();

        if (err_cnt == 0 && ks_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/aesk_pkg.sv
src/aesk_counter.sv
src/aesk_round.sv
src/aes128_ctr_keystream.sv
tb/sv/tb_aes128_ctr_keystream.sv
